// ----- hw/rtl/swmm_pkg.sv -----
// shared constants and types of the sliding window max/min pool unit
// no dependencies; imported by swmm_cell and the pooling unit top
`default_nettype none

package swmm_pkg;

    // pixel coding, full scale code means 1.0
    localparam int PIXEL_BITS = 8;
    localparam logic [PIXEL_BITS-1:0] FULL_CODE = {PIXEL_BITS{1'b1}};

    // configuration register widths
    localparam int EDGE_BITS      = 6;
    localparam int WIN_BITS       = 4;
    localparam int STRIDE_BITS    = 6;
    localparam int CFG_DATA_BITS  = 6;
    localparam int CFG_INDEX_BITS = 2;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_EDGE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_EDGE = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STRIDE      = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INVERT_MODE = 2'd3;

    // register reset values
    localparam logic [EDGE_BITS-1:0]   RST_IMAGE_EDGE  = 6'd28;
    localparam logic [WIN_BITS-1:0]    RST_WINDOW_EDGE = 4'd3;
    localparam logic [STRIDE_BITS-1:0] RST_STRIDE      = 6'd1;
    localparam logic                   RST_INVERT_MODE = 1'b1;

    // width of the domain where edges, positions and strides are compared
    localparam int CMP_BITS = 9;

    // parameter defaults
    localparam int DEF_MAX_EDGE   = 32;
    localparam int DEF_MAX_WINDOW = 8;

    // per-pixel tag carried down the pipeline
    typedef struct packed {
        logic report;
        logic last;
    } t_item_tag;

endpackage

`default_nettype wire

// ----- hw/rtl/swmm_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module swmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/swmm_cell.sv -----
// one column cell of the pooling window chain: holds a column maximum,
// shifts it to its left neighbor and merges it into the running window max
// depends on swmm_pkg
`default_nettype none

module swmm_cell
    import swmm_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int IDX        = 0,
    parameter int WW         = $clog2(DEF_MAX_WINDOW + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_shift,
    input  wire logic [PIXEL_BITS-1:0] i_col,
    input  wire logic [PIXEL_BITS-1:0] i_max,
    input  wire logic [WW-1:0]         i_win,
    output logic      [PIXEL_BITS-1:0] o_col,
    output logic      [PIXEL_BITS-1:0] o_max
);

    logic [PIXEL_BITS-1:0] r_col;
    logic                  in_win;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    // the window covers the newest w cells at the right end of the chain
    assign in_win = (CMP_BITS'(i_win) + CMP_BITS'(IDX)) >= CMP_BITS'(MAX_WINDOW);
    assign o_col  = r_col;
    assign o_max  = (in_win && (r_col > i_max)) ? r_col : i_max;

endmodule

`default_nettype wire

// ----- hw/rtl/sliding_window_max_min_pool_unit.sv -----
// Strided square max pooling over a raster pixel stream. One pixel is taken
// per clock when the result side is not stalled; a result passes through the
// column memory read with the pixel, the column chain shift and the output
// register, each held while the result side is stalled.
// The line store is a memory of MAX_EDGE words, each holding the last
// MAX_WINDOW-1 rows of one column, read and rewritten once per pixel; the
// window lives in a chain of MAX_WINDOW column-max cells. Any register write
// restarts the image at pixel 0. Invert mode reports 255 minus the window max.
// depends on swmm_pkg, swmm_ram, swmm_cell
`default_nettype none

module sliding_window_max_min_pool_unit
    import swmm_pkg::*;
#(
    parameter int MAX_EDGE   = DEF_MAX_EDGE,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration write port
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    // pixel stream
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    input  wire logic [7:0]                i_s_tdata,   // [7:0] pixel
    // result stream
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    output logic      [7:0]                o_m_tdata,   // [7:0] pooled_value
    output logic                           o_m_tuser,   // [0] no_spike
    output logic                           o_m_tlast    // last_of_image
);

    localparam int CW        = $clog2(MAX_EDGE);
    localparam int WW        = $clog2(MAX_WINDOW + 1);
    localparam int LINE_ROWS = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
    localparam int LW        = LINE_ROWS * PIXEL_BITS;

    // configuration registers
    logic [EDGE_BITS-1:0]   r_cfg_edge;
    logic [WIN_BITS-1:0]    r_cfg_win;
    logic [STRIDE_BITS-1:0] r_cfg_stride;
    logic                   r_cfg_inv;

    // position and stride phase
    logic [CW-1:0]          r_row, n_row;
    logic [CW-1:0]          r_col, n_col;
    logic [STRIDE_BITS-1:0] r_row_ph, n_row_ph;
    logic [STRIDE_BITS-1:0] r_col_ph, n_col_ph;

    // pipeline
    logic                  r_s1_valid;
    logic [PIXEL_BITS-1:0] r_s1_px;
    logic [CW-1:0]         r_s1_col;
    t_item_tag             r_s1_tag;
    logic                  r_s2_valid;
    t_item_tag             r_s2_tag;
    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_out_data;
    logic                  r_out_nospike;
    logic                  r_out_last;

    logic [CMP_BITS-1:0] e9, w9, s9, r9, c9;
    logic                adv, accept;
    logic                col_end, row_end;
    t_item_tag           tag_in;
    logic [LW-1:0]       line_rd, line_wr;
    logic [PIXEL_BITS-1:0] colmax;
    logic [WW-1:0]       win;
    logic [PIXEL_BITS-1:0] col_link [MAX_WINDOW];
    logic [PIXEL_BITS-1:0] max_link [MAX_WINDOW+1];
    logic [PIXEL_BITS-1:0] win_max, res;

    // effective edges and stride
    always_comb begin
        if (r_cfg_edge == '0) begin
            e9 = CMP_BITS'(1);
        end else if (CMP_BITS'(r_cfg_edge) > CMP_BITS'(MAX_EDGE)) begin
            e9 = CMP_BITS'(MAX_EDGE);
        end else begin
            e9 = CMP_BITS'(r_cfg_edge);
        end
        if (r_cfg_win == '0) begin
            w9 = CMP_BITS'(1);
        end else if (CMP_BITS'(r_cfg_win) > CMP_BITS'(MAX_WINDOW)) begin
            w9 = CMP_BITS'(MAX_WINDOW);
        end else begin
            w9 = CMP_BITS'(r_cfg_win);
        end
        s9 = (r_cfg_stride == '0) ? CMP_BITS'(1) : CMP_BITS'(r_cfg_stride);
    end

    assign win    = WW'(w9);
    assign r9     = CMP_BITS'(r_row);
    assign c9     = CMP_BITS'(r_col);
    assign adv    = !r_out_valid || i_m_tready;
    assign accept = i_s_tvalid && adv;

    assign col_end = (c9 + CMP_BITS'(1)) >= e9;
    assign row_end = (r9 + CMP_BITS'(1)) >= e9;

    assign tag_in.report = (w9 <= e9) && ((r9 + CMP_BITS'(1)) >= w9)
                        && ((c9 + CMP_BITS'(1)) >= w9)
                        && (r_row_ph == '0) && (r_col_ph == '0);
    assign tag_in.last   = ((r9 + s9) >= e9) && ((c9 + s9) >= e9);

    // next position and phases for an accepted pixel
    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_row_ph = r_row_ph;
        n_col_ph = r_col_ph;
        if (col_end) begin
            n_col    = '0;
            n_col_ph = '0;
            if (row_end) begin
                n_row    = '0;
                n_row_ph = '0;
            end else begin
                if ((r9 + CMP_BITS'(1)) >= w9) begin
                    n_row_ph = ((CMP_BITS'(r_row_ph) + CMP_BITS'(1)) >= s9)
                             ? '0 : r_row_ph + 1'b1;
                end else begin
                    n_row_ph = '0;
                end
                n_row = r_row + 1'b1;
            end
        end else begin
            if ((c9 + CMP_BITS'(1)) >= w9) begin
                n_col_ph = ((CMP_BITS'(r_col_ph) + CMP_BITS'(1)) >= s9)
                         ? '0 : r_col_ph + 1'b1;
            end else begin
                n_col_ph = '0;
            end
            n_col = r_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_edge   <= RST_IMAGE_EDGE;
            r_cfg_win    <= RST_WINDOW_EDGE;
            r_cfg_stride <= RST_STRIDE;
            r_cfg_inv    <= RST_INVERT_MODE;
            r_row        <= '0;
            r_col        <= '0;
            r_row_ph     <= '0;
            r_col_ph     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_IMAGE_EDGE:  r_cfg_edge   <= EDGE_BITS'(i_cfg_wdata);
                REG_WINDOW_EDGE: r_cfg_win    <= WIN_BITS'(i_cfg_wdata);
                REG_STRIDE:      r_cfg_stride <= STRIDE_BITS'(i_cfg_wdata);
                REG_INVERT_MODE: r_cfg_inv    <= i_cfg_wdata[0];
                default: begin
                end
            endcase
            // every write restarts the image
            r_row    <= '0;
            r_col    <= '0;
            r_row_ph <= '0;
            r_col_ph <= '0;
        end else if (accept) begin
            r_row    <= n_row;
            r_col    <= n_col;
            r_row_ph <= n_row_ph;
            r_col_ph <= n_col_ph;
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= i_s_tvalid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && r_s2_tag.report;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px  <= i_s_tdata[PIXEL_BITS-1:0];
            r_s1_col <= r_col;
            r_s1_tag <= tag_in;
        end
        if (adv) begin
            r_s2_tag      <= r_s1_tag;
            r_out_data    <= (res == FULL_CODE) ? '0 : res;
            r_out_nospike <= (res == FULL_CODE);
            r_out_last    <= r_s2_tag.last;
        end
    end

    // column word: slice k-1 holds the pixel k rows above the current one
    swmm_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_EDGE)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (adv && r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (line_wr),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (line_rd)
    );

    generate
        if (LINE_ROWS > 1) begin : g_line_shift
            assign line_wr = {line_rd[LW-PIXEL_BITS-1:0], r_s1_px};
        end else begin : g_line_single
            assign line_wr = r_s1_px;
        end
    endgenerate

    // maximum of the incoming column over the current row and the w-1 rows above it
    always_comb begin
        colmax = r_s1_px;
        for (int k = 1; k < MAX_WINDOW; k++) begin
            if ((CMP_BITS'(k) < w9) && (line_rd[(k-1)*PIXEL_BITS +: PIXEL_BITS] > colmax)) begin
                colmax = line_rd[(k-1)*PIXEL_BITS +: PIXEL_BITS];
            end
        end
    end

    // window chain, newest column enters at the right end
    assign max_link[0] = '0;

    generate
        for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
            logic [PIXEL_BITS-1:0] col_in;
            if (j == MAX_WINDOW - 1) begin : g_head
                assign col_in = colmax;
            end else begin : g_body
                assign col_in = col_link[j+1];
            end
            swmm_cell #(
                .MAX_WINDOW (MAX_WINDOW),
                .IDX        (j),
                .WW         (WW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_shift (adv && r_s1_valid),
                .i_col   (col_in),
                .i_max   (max_link[j]),
                .i_win   (win),
                .o_col   (col_link[j]),
                .o_max   (max_link[j+1])
            );
        end
    endgenerate

    assign win_max = max_link[MAX_WINDOW];
    assign res     = r_cfg_inv ? (FULL_CODE - win_max) : win_max;

    assign o_s_tready = adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = 8'(r_out_data);
    assign o_m_tuser  = r_out_nospike;
    assign o_m_tlast  = r_out_last;

    // position stays inside the effective image
    a_col_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c9 < e9 && r9 < e9)
        else $error("position outside image");

    // stride phases stay below the stride
    a_phase_in_stride: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_BITS'(r_col_ph) < s9 && CMP_BITS'(r_row_ph) < s9)
        else $error("stride phase overrun");

    // a register write restarts the image
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (r_row == '0 && r_col == '0 && r_row_ph == '0 && r_col_ph == '0))
        else $error("register write did not restart image");

    // a new result always comes from a reporting pixel in the last stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s2_valid && r_s2_tag.report))
        else $error("result without reporting pixel");

    // a no-spike result carries a zero value
    a_nospike_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_nospike) |-> r_out_data == '0)
        else $error("no-spike result with nonzero value");

endmodule

`default_nettype wire
